/* src/sos_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sos_pkg;

	// default widths of the datapath
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 40;

	// fixed field widths
	localparam int VOXEL_BITS = 16;
	localparam int THR_BITS   = 16;
	localparam int ACC_BITS   = 56;
	localparam int OUT_CNT_W  = 40;
	localparam int DICE_BITS  = 17;
	localparam int MEAN_BITS  = 16;

	// quotient bits of the shared divider: 17 result bits plus one overflow bit
	localparam int QUOT_BITS = 18;

	// region results waiting between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam logic [THR_BITS-1:0] THR_RESET = 16'h8000;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_TOTAL,
		BK_DICE_GO,
		BK_DICE_WAIT,
		BK_MEAN_GO,
		BK_MEAN_WAIT,
		BK_OUT
	} bk_state_t;

endpackage

`default_nettype wire

/* src/segmentation_overlap_stats_unit.sv */
// a region's last voxel passes stages s1 and s2 before its snapshot is pushed into the result queue;
//   the result is presented after two divisions
//   on one shared divider
// throughput: one voxel transaction per cycle while in_stall is low; the back end finishes
//   one region result before it pops the next; four finished regions queue before in_stall rises
// reset: arst_n clears counters, sums, queue and control; fg_threshold returns to 32768
`timescale 1ns / 1ps
`default_nettype none

module segmentation_overlap_stats_unit #(
	parameter int SAMPLE_BITS = sos_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = sos_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// threshold register
	input  wire logic                              cfg_wr_en,
	input  wire logic [sos_pkg::THR_BITS-1:0]      cfg_wr_data,
	// voxel pair channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sos_pkg::VOXEL_BITS-1:0]    voxel_a,
	input  wire logic [sos_pkg::VOXEL_BITS-1:0]    voxel_b,
	input  wire logic                              last_voxel,
	// region result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [sos_pkg::OUT_CNT_W-1:0]          voxel_total,
	output logic [sos_pkg::OUT_CNT_W-1:0]          fg_only_a,
	output logic [sos_pkg::OUT_CNT_W-1:0]          fg_only_b,
	output logic [sos_pkg::OUT_CNT_W-1:0]          fg_both,
	output logic [sos_pkg::OUT_CNT_W-1:0]          bg_both,
	output logic [sos_pkg::ACC_BITS-1:0]           abs_diff_sum,
	output logic [sos_pkg::ACC_BITS-1:0]           sq_diff_sum,
	output logic [sos_pkg::DICE_BITS-1:0]          dice_q16,
	output logic [sos_pkg::MEAN_BITS-1:0]          mean_abs_diff
);
	import sos_pkg::*;

	// one region snapshot: four counts and two sums
	localparam int SNAP_W = 4 * COUNT_BITS + 2 * ACC_BITS;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;
	logic [SNAP_W-1:0] q_wr_data;
	logic [SNAP_W-1:0] q_rd_data;

	// front: threshold compare, |a-b| and its square in a short pipeline,
	// saturating counters and sums; a last voxel pushes the snapshot and clears
	sos_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.QCNT_W      (QCNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.voxel_a     (voxel_a),
		.voxel_b     (voxel_b),
		.last_voxel  (last_voxel),
		.q_count     (q_count),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	// queue of finished regions, lets voxels keep streaming while
	// the back end divides or the consumer stalls
	sos_queue #(
		.W     (SNAP_W),
		.DEPTH (QUEUE_DEPTH),
		.CNT_W (QCNT_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.count   (q_count),
		.empty   (q_empty)
	);

	// back: saturating total, dice and mean through one serial divider,
	// result held on the output until the transaction completes
	sos_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rd_data),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.voxel_total   (voxel_total),
		.fg_only_a     (fg_only_a),
		.fg_only_b     (fg_only_b),
		.fg_both       (fg_both),
		.bg_both       (bg_both),
		.abs_diff_sum  (abs_diff_sum),
		.sq_diff_sum   (sq_diff_sum),
		.dice_q16      (dice_q16),
		.mean_abs_diff (mean_abs_diff)
	);

endmodule

`default_nettype wire

/* src/sos_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sos_front #(
	parameter int SAMPLE_BITS = sos_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = sos_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = sos_pkg::QUEUE_DEPTH,
	parameter int QCNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          cfg_wr_en,
	input  wire logic [sos_pkg::THR_BITS-1:0]                  cfg_wr_data,
	input  wire logic                                          in_valid,
	output logic                                               in_stall,
	input  wire logic [sos_pkg::VOXEL_BITS-1:0]                voxel_a,
	input  wire logic [sos_pkg::VOXEL_BITS-1:0]                voxel_b,
	input  wire logic                                          last_voxel,
	input  wire logic [QCNT_W-1:0]                             q_count,
	output logic                                               q_push,
	output logic [4*COUNT_BITS+2*sos_pkg::ACC_BITS-1:0]        q_data
);
	import sos_pkg::*;

	typedef struct packed {
		logic [COUNT_BITS-1:0] both;
		logic [COUNT_BITS-1:0] only_a;
		logic [COUNT_BITS-1:0] only_b;
		logic [COUNT_BITS-1:0] bg;
		logic [ACC_BITS-1:0]   abs_sum;
		logic [ACC_BITS-1:0]   sq_sum;
	} snap_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [ACC_BITS-1:0]   ACC_MAX = '1;

	logic [THR_BITS-1:0] thr_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] a_in;
	logic [SAMPLE_BITS-1:0] b_in;
	logic [SAMPLE_BITS-1:0] thr;
	logic                   fa_in;
	logic                   fb_in;
	logic [SAMPLE_BITS-1:0] d_in;

	logic                   vld_s1;
	logic                   last_s1;
	logic                   fa_s1;
	logic                   fb_s1;
	logic [SAMPLE_BITS-1:0] d_s1;

	logic                     vld_s2;
	logic                     last_s2;
	logic                     fa_s2;
	logic                     fb_s2;
	logic [SAMPLE_BITS-1:0]   d_s2;
	logic [2*SAMPLE_BITS-1:0] prod_s2;

	logic [COUNT_BITS-1:0] both_q, oa_q, ob_q, bg_q;
	logic [ACC_BITS-1:0]   abs_q, sq_q;

	logic [COUNT_BITS-1:0]    both_nx, oa_nx, ob_nx, bg_nx;
	logic [ACC_BITS-1:0]      abs_nx, sq_nx;
	logic [ACC_BITS:0]        abs_sum_w, sq_sum_w;
	logic [2*SAMPLE_BITS-1:0] sq_term;
	logic [QCNT_W:0]          occ;
	snap_t                    snap;

	// room in the queue for every region end still in flight plus the new one
	assign occ = {1'b0, q_count} + (QCNT_W+1)'(vld_s1 && last_s1)
		+ (QCNT_W+1)'(vld_s2 && last_s2);
	assign in_stall = (occ >= (QCNT_W+1)'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;

	assign a_in  = voxel_a[SAMPLE_BITS-1:0];
	assign b_in  = voxel_b[SAMPLE_BITS-1:0];
	assign thr   = thr_q[SAMPLE_BITS-1:0];
	assign fa_in = (a_in > thr);
	assign fb_in = (b_in > thr);
	assign d_in  = (a_in >= b_in) ? (a_in - b_in) : (b_in - a_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= last_voxel;
		fa_s1   <= fa_in;
		fb_s1   <= fb_in;
		d_s1    <= d_in;
		last_s2 <= last_s1;
		fa_s2   <= fa_s1;
		fb_s2   <= fb_s1;
		d_s2    <= d_s1;
		prod_s2 <= d_s1 * d_s1;
	end

	// classification into one of four counters, saturating
	always_comb begin
		both_nx = both_q;
		oa_nx   = oa_q;
		ob_nx   = ob_q;
		bg_nx   = bg_q;
		if (fa_s2 && fb_s2) begin
			both_nx = (both_q == CNT_MAX) ? both_q : both_q + 1'b1;
		end else if (fa_s2) begin
			oa_nx = (oa_q == CNT_MAX) ? oa_q : oa_q + 1'b1;
		end else if (fb_s2) begin
			ob_nx = (ob_q == CNT_MAX) ? ob_q : ob_q + 1'b1;
		end else begin
			bg_nx = (bg_q == CNT_MAX) ? bg_q : bg_q + 1'b1;
		end
	end

	assign sq_term   = prod_s2 >> 16;
	assign abs_sum_w = {1'b0, abs_q} + (ACC_BITS+1)'(d_s2);
	assign sq_sum_w  = {1'b0, sq_q} + (ACC_BITS+1)'(sq_term);
	assign abs_nx    = abs_sum_w[ACC_BITS] ? ACC_MAX : abs_sum_w[ACC_BITS-1:0];
	assign sq_nx     = sq_sum_w[ACC_BITS] ? ACC_MAX : sq_sum_w[ACC_BITS-1:0];

	always_comb begin
		snap.both    = both_nx;
		snap.only_a  = oa_nx;
		snap.only_b  = ob_nx;
		snap.bg      = bg_nx;
		snap.abs_sum = abs_nx;
		snap.sq_sum  = sq_nx;
	end

	assign q_push = vld_s2 && last_s2;
	assign q_data = snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			both_q <= '0;
			oa_q   <= '0;
			ob_q   <= '0;
			bg_q   <= '0;
			abs_q  <= '0;
			sq_q   <= '0;
		end else if (vld_s2) begin
			if (last_s2) begin
				both_q <= '0;
				oa_q   <= '0;
				ob_q   <= '0;
				bg_q   <= '0;
				abs_q  <= '0;
				sq_q   <= '0;
			end else begin
				both_q <= both_nx;
				oa_q   <= oa_nx;
				ob_q   <= ob_nx;
				bg_q   <= bg_nx;
				abs_q  <= abs_nx;
				sq_q   <= sq_nx;
			end
		end
	end

	a_no_overcommit: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (QCNT_W+1)'(QUEUE_DEPTH + 2))
		else $error("front: queue overcommitted");

endmodule

`default_nettype wire

/* src/sos_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sos_queue #(
	parameter int W     = 4 * sos_pkg::COUNT_BITS_DEF + 2 * sos_pkg::ACC_BITS,
	parameter int DEPTH = sos_pkg::QUEUE_DEPTH,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [W-1:0]     wr_data,
	input  wire logic             pop,
	output logic      [W-1:0]     rd_data,
	output logic      [CNT_W-1:0] count,
	output logic                  empty
);
	import sos_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [W-1:0]     rd_data_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// rd_data holds the entry taken by the latest pop until the next pop
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
		if (pop) begin
			rd_data_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;
	assign empty   = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("queue: write while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue: read while empty");

endmodule

`default_nettype wire

/* src/sos_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module sos_div #(
	parameter int W     = 60,
	parameter int DEN_W = 42,
	parameter int QW    = sos_pkg::QUOT_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [W-1:0]     num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [QW-1:0]    quot
);
	import sos_pkg::*;

	localparam int STEP_W = $clog2(QW + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      dsh_q;
	logic [QW-1:0]     quot_q;
	logic              ge;

	// restoring division, one quotient bit a cycle, msb first
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= W'(den) << (QW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

/* src/sos_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sos_back #(
	parameter int COUNT_BITS = sos_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      q_empty,
	input  wire logic [4*COUNT_BITS+2*sos_pkg::ACC_BITS-1:0] q_data,
	output logic                                           q_pop,
	output logic                                           out_valid,
	input  wire logic                                      out_stall,
	output logic [sos_pkg::OUT_CNT_W-1:0]                  voxel_total,
	output logic [sos_pkg::OUT_CNT_W-1:0]                  fg_only_a,
	output logic [sos_pkg::OUT_CNT_W-1:0]                  fg_only_b,
	output logic [sos_pkg::OUT_CNT_W-1:0]                  fg_both,
	output logic [sos_pkg::OUT_CNT_W-1:0]                  bg_both,
	output logic [sos_pkg::ACC_BITS-1:0]                   abs_diff_sum,
	output logic [sos_pkg::ACC_BITS-1:0]                   sq_diff_sum,
	output logic [sos_pkg::DICE_BITS-1:0]                  dice_q16,
	output logic [sos_pkg::MEAN_BITS-1:0]                  mean_abs_diff
);
	import sos_pkg::*;

	typedef struct packed {
		logic [COUNT_BITS-1:0] both;
		logic [COUNT_BITS-1:0] only_a;
		logic [COUNT_BITS-1:0] only_b;
		logic [COUNT_BITS-1:0] bg;
		logic [ACC_BITS-1:0]   abs_sum;
		logic [ACC_BITS-1:0]   sq_sum;
	} snap_t;

	localparam int DEN_W = COUNT_BITS + 2;
	localparam int DIV_W = (COUNT_BITS + 20 > ACC_BITS + 1) ? COUNT_BITS + 20 : ACC_BITS + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	bk_state_t state_q, state_nx;

	snap_t                 snap;
	logic [COUNT_BITS-1:0] sab_q, scd_q, total_q;
	logic [DEN_W-1:0]      den_q;
	logic [DICE_BITS-1:0]  dice_q;
	logic [MEAN_BITS-1:0]  mean_q;

	logic [COUNT_BITS:0]   sab_w, scd_w, tot_w;
	logic [DEN_W-1:0]      den_w;
	logic                  div_start;
	logic [DIV_W-1:0]      div_num;
	logic [DEN_W-1:0]      div_den;
	logic                  div_done;
	logic [QUOT_BITS-1:0]  div_quot;
	logic                  ld_dice;
	logic                  ld_mean;

	// the popped snapshot stays on the queue output until the next pop
	assign snap = q_data;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_nx = BK_SUM;
				end
			end
			BK_SUM:       state_nx = BK_TOTAL;
			BK_TOTAL:     state_nx = BK_DICE_GO;
			BK_DICE_GO:   state_nx = BK_DICE_WAIT;
			BK_DICE_WAIT: begin
				if (div_done) begin
					state_nx = BK_MEAN_GO;
				end
			end
			BK_MEAN_GO:   state_nx = BK_MEAN_WAIT;
			BK_MEAN_WAIT: begin
				if (div_done) begin
					state_nx = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!out_stall) begin
					state_nx = BK_IDLE;
				end
			end
			default:      state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		ld_dice   = 1'b0;
		ld_mean   = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			BK_IDLE:      q_pop = !q_empty;
			BK_DICE_GO:   div_start = 1'b1;
			BK_DICE_WAIT: ld_dice = div_done;
			BK_MEAN_GO:   div_start = 1'b1;
			BK_MEAN_WAIT: ld_mean = div_done;
			BK_OUT:       out_valid = 1'b1;
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// pairwise saturating sums toward the total, and the dice denominator
	assign sab_w = {1'b0, snap.both} + {1'b0, snap.only_a};
	assign scd_w = {1'b0, snap.only_b} + {1'b0, snap.bg};
	assign tot_w = {1'b0, sab_q} + {1'b0, scd_q};
	assign den_w = DEN_W'(snap.only_a) + DEN_W'(snap.only_b)
		+ (DEN_W'(snap.both) << 1);

	// numerators carry the half-divisor for round half up
	always_comb begin
		if (state_q == BK_MEAN_GO) begin
			div_num = DIV_W'(snap.abs_sum) + DIV_W'(total_q >> 1);
			div_den = DEN_W'(total_q);
		end else begin
			div_num = (DIV_W'(snap.both) << 17) + DIV_W'(den_q >> 1);
			div_den = den_q;
		end
	end

	sos_div #(
		.W     (DIV_W),
		.DEN_W (DEN_W),
		.QW    (QUOT_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (state_q == BK_SUM) begin
			sab_q <= sab_w[COUNT_BITS] ? CNT_MAX : sab_w[COUNT_BITS-1:0];
			scd_q <= scd_w[COUNT_BITS] ? CNT_MAX : scd_w[COUNT_BITS-1:0];
			den_q <= den_w;
		end
		if (state_q == BK_TOTAL) begin
			total_q <= tot_w[COUNT_BITS] ? CNT_MAX : tot_w[COUNT_BITS-1:0];
		end
		if (ld_dice) begin
			dice_q <= (den_q == '0) ? '0 : div_quot[DICE_BITS-1:0];
		end
		if (ld_mean) begin
			// no voxels gives zero, a quotient beyond 16 bits is capped
			if (total_q == '0) begin
				mean_q <= '0;
			end else if (div_quot[QUOT_BITS-1] || div_quot[QUOT_BITS-2]) begin
				mean_q <= '1;
			end else begin
				mean_q <= div_quot[MEAN_BITS-1:0];
			end
		end
	end

	assign voxel_total   = OUT_CNT_W'(total_q);
	assign fg_only_a     = OUT_CNT_W'(snap.only_a);
	assign fg_only_b     = OUT_CNT_W'(snap.only_b);
	assign fg_both       = OUT_CNT_W'(snap.both);
	assign bg_both       = OUT_CNT_W'(snap.bg);
	assign abs_diff_sum  = snap.abs_sum;
	assign sq_diff_sum   = snap.sq_sum;
	assign dice_q16      = dice_q;
	assign mean_abs_diff = mean_q;

	a_out_after_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MEAN_WAIT && div_done) |=> out_valid)
		else $error("back: result not presented after mean division");

	a_dice_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dice_q16 <= DICE_BITS'(65536)))
		else $error("back: dice score above one");

endmodule

`default_nettype wire

/* tb/segmentation_overlap_stats_unit_tb.sv */
`timescale 1ns / 1ps

module segmentation_overlap_stats_unit_tb;
	import sos_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 8;
	// two divisions on the shared divider plus queue hand-off, with margin
	localparam int SETTLE_CYCLES  = 60;
	// cycles with no transaction on either channel before giving up
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 140;
	localparam int NUM_PHASES     = 6;
	localparam int NUM_ROWS       = 18;

	localparam logic [63:0] COUNT_SAT = (64'd1 << COUNT_BITS_DEF) - 64'd1;
	localparam logic [63:0] ACC_SAT   = (64'd1 << ACC_BITS) - 64'd1;
	localparam logic [63:0] MEAN_SAT  = (64'd1 << MEAN_BITS) - 64'd1;

	// one region result, field for field as the block emits it
	typedef struct packed {
		logic [OUT_CNT_W-1:0] total;
		logic [OUT_CNT_W-1:0] only_a;
		logic [OUT_CNT_W-1:0] only_b;
		logic [OUT_CNT_W-1:0] both;
		logic [OUT_CNT_W-1:0] bg;
		logic [ACC_BITS-1:0]  abs_sum;
		logic [ACC_BITS-1:0]  sq_sum;
		logic [DICE_BITS-1:0] dice;
		logic [MEAN_BITS-1:0] mean;
	} region_stats_t;

	// directed stimulus row; typed rows carry their result written out by hand
	typedef struct packed {
		logic [VOXEL_BITS-1:0] a;
		logic [VOXEL_BITS-1:0] b;
		logic                  is_last;
		logic                  typed;
		region_stats_t         stats;
	} voxel_row_t;

	// dut signals; the inputs are known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [THR_BITS-1:0]   cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [VOXEL_BITS-1:0] voxel_a = '0;
	logic [VOXEL_BITS-1:0] voxel_b = '0;
	logic                  last_voxel = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [OUT_CNT_W-1:0]  voxel_total;
	logic [OUT_CNT_W-1:0]  fg_only_a;
	logic [OUT_CNT_W-1:0]  fg_only_b;
	logic [OUT_CNT_W-1:0]  fg_both;
	logic [OUT_CNT_W-1:0]  bg_both;
	logic [ACC_BITS-1:0]   abs_diff_sum;
	logic [ACC_BITS-1:0]   sq_diff_sum;
	logic [DICE_BITS-1:0]  dice_q16;
	logic [MEAN_BITS-1:0]  mean_abs_diff;

	// shadow of the threshold register and of the open region's tallies
	logic [THR_BITS-1:0] fg_threshold_q;
	logic [63:0]         acc_both_fg;
	logic [63:0]         acc_only_a;
	logic [63:0]         acc_only_b;
	logic [63:0]         acc_both_bg;
	logic [63:0]         acc_abs;
	logic [63:0]         acc_sq;

	region_stats_t pending_regions[$];
	voxel_row_t    directed_rows[NUM_ROWS];
	bit            failed = 1'b0;
	int            burst_left = 0;
	int            idle_cycles = 0;
	int            stall_mode = 0;
	int            stall_left = 0;

	segmentation_overlap_stats_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.voxel_a       (voxel_a),
		.voxel_b       (voxel_b),
		.last_voxel    (last_voxel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.voxel_total   (voxel_total),
		.fg_only_a     (fg_only_a),
		.fg_only_b     (fg_only_b),
		.fg_both       (fg_both),
		.bg_both       (bg_both),
		.abs_diff_sum  (abs_diff_sum),
		.sq_diff_sum   (sq_diff_sum),
		.dice_q16      (dice_q16),
		.mean_abs_diff (mean_abs_diff)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [63:0] sat_count_add(input logic [63:0] x, input logic [63:0] y);
		return (x + y > COUNT_SAT) ? COUNT_SAT : x + y;
	endfunction

	function automatic void clear_region();
		acc_both_fg = '0;
		acc_only_a  = '0;
		acc_only_b  = '0;
		acc_both_bg = '0;
		acc_abs     = '0;
		acc_sq      = '0;
	endfunction

	// folds one voxel pair into the open region; returns 1 when the region closes
	function automatic bit accumulate_voxel(input logic [VOXEL_BITS-1:0] a,
			input logic [VOXEL_BITS-1:0] b, input logic is_last,
			output region_stats_t stats);
		logic [63:0] diff;
		logic [63:0] sq_term;
		logic [63:0] total;
		logic [63:0] den;
		logic [63:0] dice;
		logic [63:0] mean;
		bit          fa;
		bit          fb;
		stats = '0;
		fa = a > fg_threshold_q;
		fb = b > fg_threshold_q;
		diff = (a >= b) ? {48'd0, a - b} : {48'd0, b - a};
		sq_term = (diff * diff) >> 16;

		// exactly one of the four classes gets the voxel
		if (fa && fb)
			acc_both_fg = sat_count_add(acc_both_fg, 64'd1);
		else if (fa)
			acc_only_a = sat_count_add(acc_only_a, 64'd1);
		else if (fb)
			acc_only_b = sat_count_add(acc_only_b, 64'd1);
		else
			acc_both_bg = sat_count_add(acc_both_bg, 64'd1);

		acc_abs = (diff > ACC_SAT - acc_abs) ? ACC_SAT : acc_abs + diff;
		acc_sq  = (sq_term > ACC_SAT - acc_sq) ? ACC_SAT : acc_sq + sq_term;

		if (!is_last)
			return 1'b0;

		total = sat_count_add(sat_count_add(acc_both_fg, acc_only_a),
			sat_count_add(acc_only_b, acc_both_bg));

		// dice undefined with no foreground anywhere: report 0
		den = acc_only_a + acc_only_b + 2 * acc_both_fg;
		dice = (den == 0) ? 64'd0 : ((acc_both_fg << 17) + den / 2) / den;

		// rounded mean, capped to the field
		mean = (total == 0) ? 64'd0 : (acc_abs + total / 2) / total;
		if (mean > MEAN_SAT)
			mean = MEAN_SAT;

		stats.total   = total[OUT_CNT_W-1:0];
		stats.only_a  = acc_only_a[OUT_CNT_W-1:0];
		stats.only_b  = acc_only_b[OUT_CNT_W-1:0];
		stats.both    = acc_both_fg[OUT_CNT_W-1:0];
		stats.bg      = acc_both_bg[OUT_CNT_W-1:0];
		stats.abs_sum = acc_abs[ACC_BITS-1:0];
		stats.sq_sum  = acc_sq[ACC_BITS-1:0];
		stats.dice    = dice[DICE_BITS-1:0];
		stats.mean    = mean[MEAN_BITS-1:0];
		clear_region();
		return 1'b1;
	endfunction

	// random voxel, weighted toward the extremes and the threshold edge
	function automatic logic [VOXEL_BITS-1:0] pick_voxel();
		int t;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: begin
				t = int'(fg_threshold_q) + int'($urandom_range(0, 4)) - 2;
				if (t < 0)
					t = 0;
				if (t > 65535)
					t = 65535;
				return VOXEL_BITS'(t);
			end
			default: return VOXEL_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// one voxel transaction; the sender may idle between bursts of random length
	task automatic send_voxel(input logic [VOXEL_BITS-1:0] a, input logic [VOXEL_BITS-1:0] b,
			input logic is_last, input logic typed, input region_stats_t typed_stats);
		region_stats_t predicted;
		int            gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid   <= 1'b1;
		voxel_a    <= a;
		voxel_b    <= b;
		last_voxel <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		if (accumulate_voxel(a, b, is_last, predicted))
			pending_regions.push_back(typed ? typed_stats : predicted);
	endtask

	// hold the sender until every region result is back, then let the pipe settle
	task automatic wait_results_done(input int settle);
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending_regions.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_BITS-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fg_threshold_q = value;
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// receiver: stall behavior changes in stretches (none, coin flip, mostly stalled)
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 120);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// compare each accepted region result with the oldest prediction
	always @(posedge clk) begin : result_check
		region_stats_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_regions.size() == 0) begin
				$error("region result with no prediction waiting");
				failed = 1'b1;
			end else begin
				want = pending_regions.pop_front();
				check_field("voxel_total", want.total, voxel_total);
				check_field("fg_only_a", want.only_a, fg_only_a);
				check_field("fg_only_b", want.only_b, fg_only_b);
				check_field("fg_both", want.both, fg_both);
				check_field("bg_both", want.bg, bg_both);
				check_field("abs_diff_sum", want.abs_sum, abs_diff_sum);
				check_field("sq_diff_sum", want.sq_sum, sq_diff_sum);
				check_field("dice_q16", want.dice, dice_q16);
				check_field("mean_abs_diff", want.mean, mean_abs_diff);
			end
		end
	end

	// watchdog: a run that stops moving is a failure
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int                    p;
		int                    i;
		int                    len;
		int                    items_left;
		logic [VOXEL_BITS-1:0] a;
		logic [VOXEL_BITS-1:0] b;
		logic [THR_BITS-1:0]   thr;
		logic [THR_BITS-1:0]   fixed_thr[4];

		fixed_thr = '{16'h0000, 16'hffff, 16'h0001, 16'h8000};

		// threshold is 32768 out of reset for all of these
		// fields: total, only_a, only_b, both, bg, abs, sq, dice, mean
		directed_rows = '{
			// single background voxel, empty foreground gives dice 0
			'{16'h0000, 16'h0000, 1'b1, 1'b1,
				'{40'd1, 40'd0, 40'd0, 40'd0, 40'd1, 56'd0, 56'd0, 17'd0, 16'd0}},
			// full-scale difference, first volume only
			'{16'hffff, 16'h0000, 1'b1, 1'b1,
				'{40'd1, 40'd1, 40'd0, 40'd0, 40'd0, 56'd65535, 56'd65534, 17'd0, 16'd65535}},
			// full-scale difference, second volume only
			'{16'h0000, 16'hffff, 1'b1, 1'b1,
				'{40'd1, 40'd0, 40'd1, 40'd0, 40'd0, 56'd65535, 56'd65534, 17'd0, 16'd65535}},
			// perfect overlap, dice at 1.0
			'{16'hffff, 16'hffff, 1'b1, 1'b1,
				'{40'd1, 40'd0, 40'd0, 40'd1, 40'd0, 56'd0, 56'd0, 17'd65536, 16'd0}},
			// threshold edge: equal is background, one above is foreground
			'{16'h8000, 16'h8001, 1'b1, 1'b1,
				'{40'd1, 40'd0, 40'd1, 40'd0, 40'd0, 56'd1, 56'd0, 17'd0, 16'd1}},
			'{16'h8001, 16'h8000, 1'b1, 1'b1,
				'{40'd1, 40'd1, 40'd0, 40'd0, 40'd0, 56'd1, 56'd0, 17'd0, 16'd1}},
			'{16'h8000, 16'h8000, 1'b1, 1'b1,
				'{40'd1, 40'd0, 40'd0, 40'd0, 40'd1, 56'd0, 56'd0, 17'd0, 16'd0}},
			// mixed multi-voxel region, checked by prediction
			'{16'haaaa, 16'h5555, 1'b0, 1'b0, '0},
			'{16'h5555, 16'haaaa, 1'b0, 1'b0, '0},
			'{16'hffff, 16'h8001, 1'b0, 1'b0, '0},
			'{16'h8000, 16'h0001, 1'b0, 1'b0, '0},
			'{16'h1234, 16'hfedc, 1'b0, 1'b0, '0},
			'{16'hfedc, 16'h1234, 1'b0, 1'b0, '0},
			'{16'h0001, 16'h0000, 1'b0, 1'b0, '0},
			'{16'hc000, 16'hc000, 1'b1, 1'b0, '0},
			// partial overlap, dice rounding
			'{16'hffff, 16'h0000, 1'b0, 1'b0, '0},
			'{16'h0000, 16'hffff, 1'b0, 1'b0, '0},
			'{16'hffff, 16'hffff, 1'b1, 1'b0, '0}
		};

		fg_threshold_q = THR_RESET;
		clear_region();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < NUM_ROWS; i++)
			send_voxel(directed_rows[i].a, directed_rows[i].b, directed_rows[i].is_last,
				directed_rows[i].typed, directed_rows[i].stats);
		wait_results_done(SETTLE_CYCLES);

		// random regions under several thresholds, extremes first
		for (p = 0; p < NUM_PHASES; p++) begin
			thr = (p < 4) ? fixed_thr[p] : THR_BITS'($urandom_range(0, 65535));
			write_threshold(thr);
			items_left = PHASE_ITEMS;
			while (items_left > 0) begin
				len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 60))
					: int'($urandom_range(1, 16));
				for (i = 0; i < len; i++) begin
					a = pick_voxel();
					b = ($urandom_range(0, 5) == 0) ? a : pick_voxel();
					send_voxel(a, b, i == len - 1, 1'b0, '0);
					items_left--;
				end
				// occasional full drain in the middle of a phase
				if ($urandom_range(0, 24) == 0)
					wait_results_done(0);
			end
			wait_results_done(SETTLE_CYCLES);
		end

		if (!failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
